// ===== design/rpfs_pkg.sv =====
`timescale 1ns / 1ps
package rpfs_pkg;

  localparam int MAX_BALLS    = 8;
  localparam int PROFILE_ROWS = 256;
  localparam int FRAC_BITS    = 16;
  localparam int T_BITS       = 30;

  localparam int BALL_W    = $clog2(MAX_BALLS);
  localparam int ROW_W     = $clog2(PROFILE_ROWS);
  localparam int ADDR_W    = BALL_W + ROW_W;
  localparam int MEM_DEPTH = MAX_BALLS * PROFILE_ROWS;
  localparam int BC_W      = 4;
  localparam int CNT_W     = BC_W + 1;
  localparam int IT_W      = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BALL_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ORIGIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING = 2'd2;

  localparam logic [1:0] KIND_ROW    = 2'd0;
  localparam logic [1:0] KIND_CENTER = 2'd1;
  localparam logic [1:0] KIND_FREQ   = 2'd2;
  localparam logic [1:0] KIND_EVAL   = 2'd3;

  localparam logic [IT_W-1:0] ROOT_LAST = IT_W'(31);
  localparam logic [IT_W-1:0] DIV_LAST  = IT_W'(T_BITS - 1);
  localparam logic [CNT_W-1:0] BALL_LIMIT = CNT_W'(MAX_BALLS);
  localparam logic [ROW_W:0]   ROWS_MIN   = (ROW_W + 1)'(2);
  localparam logic [ROW_W-1:0] ROW_ONE    = ROW_W'(1);
  localparam logic [ROW_W-1:0] ROW_ZERO   = '0;

  typedef struct packed {
    logic [31:0]      rad;
    logic [2:0][31:0] amp;
  } row_t;

  typedef enum logic [1:0] {MODE_LO, MODE_ZERO, MODE_INTERP} mode_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_POS, ST_BALL, ST_DIFF, ST_SQR, ST_SQACC, ST_ROOT_INIT, ST_ROOT,
    ST_CHECK_N, ST_RD_FIRST, ST_WT_FIRST, ST_WT_LAST, ST_SRCH, ST_SRCH_WT,
    ST_DIV_INIT, ST_DIV, ST_COMP, ST_INT_MUL, ST_INT_ADD, ST_FRQ_MUL, ST_ACC,
    ST_NEXT, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_IDLE, OP_POS, OP_BALL, OP_DIFF, OP_SQR, OP_SQACC, OP_ROOT_INIT,
    OP_ROOT, OP_RD_FIRST, OP_WT_FIRST, OP_WT_LAST, OP_SRCH_RD, OP_SRCH_WT,
    OP_DIV_INIT, OP_DIV, OP_COMP, OP_INT_MUL, OP_INT_ADD, OP_FRQ_MUL, OP_ACC,
    OP_NEXT, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic eval_accept;
    logic last_axis;
    logic ball_done;
    logic root_last;
    logic n_small;
    logic r_le_first;
    logic r_ge_last;
    logic span_gt1;
    logic div_bad;
    logic div_last;
    logic interp;
    logic last_comp;
    logic out_free;
  } status_t;

endpackage

// ===== design/rpfs_if.sv =====
`timescale 1ns / 1ps
interface rpfs_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         ball;
  logic [7:0]         row;
  logic               last_row;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic signed [31:0] value_c;
  logic signed [31:0] value_d;
  logic [9:0]         grid_x;
  logic [9:0]         grid_y;
  logic [9:0]         grid_z;

  modport source (output valid, kind, ball, row, last_row, value_a, value_b, value_c,
                  value_d, grid_x, grid_y, grid_z, input ready);
  modport sink (input valid, kind, ball, row, last_row, value_a, value_b, value_c,
                value_d, grid_x, grid_y, grid_z, output ready);
endinterface

interface rpfs_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] field_0;
  logic signed [31:0] field_1;
  logic signed [31:0] field_2;
  logic signed [31:0] velocity_0;
  logic signed [31:0] velocity_1;
  logic signed [31:0] velocity_2;
  logic               saturated;

  modport source (output valid, field_0, field_1, field_2, velocity_0, velocity_1,
                  velocity_2, saturated, input ready);
  modport sink (input valid, field_0, field_1, field_2, velocity_0, velocity_1,
                velocity_2, saturated, output ready);
endinterface

// ===== design/rpfs_ctrl.sv =====
`timescale 1ns / 1ps
module rpfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  rpfs_pkg::status_t status,
  output rpfs_pkg::cmd_t    cmd
);

  rpfs_pkg::state_t state;
  rpfs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rpfs_pkg::ST_IDLE:
        if (status.eval_accept) state_next = rpfs_pkg::ST_POS;
      rpfs_pkg::ST_POS:
        if (status.last_axis) state_next = rpfs_pkg::ST_BALL;
      rpfs_pkg::ST_BALL:
        state_next = status.ball_done ? rpfs_pkg::ST_DONE : rpfs_pkg::ST_DIFF;
      rpfs_pkg::ST_DIFF:      state_next = rpfs_pkg::ST_SQR;
      rpfs_pkg::ST_SQR:       state_next = rpfs_pkg::ST_SQACC;
      rpfs_pkg::ST_SQACC:
        state_next = status.last_axis ? rpfs_pkg::ST_ROOT_INIT : rpfs_pkg::ST_DIFF;
      rpfs_pkg::ST_ROOT_INIT: state_next = rpfs_pkg::ST_ROOT;
      rpfs_pkg::ST_ROOT:
        if (status.root_last) state_next = rpfs_pkg::ST_CHECK_N;
      rpfs_pkg::ST_CHECK_N:
        state_next = status.n_small ? rpfs_pkg::ST_NEXT : rpfs_pkg::ST_RD_FIRST;
      rpfs_pkg::ST_RD_FIRST:  state_next = rpfs_pkg::ST_WT_FIRST;
      rpfs_pkg::ST_WT_FIRST:  state_next = rpfs_pkg::ST_WT_LAST;
      rpfs_pkg::ST_WT_LAST:
        state_next = (status.r_le_first || status.r_ge_last) ?
                     rpfs_pkg::ST_COMP : rpfs_pkg::ST_SRCH;
      rpfs_pkg::ST_SRCH:
        state_next = status.span_gt1 ? rpfs_pkg::ST_SRCH_WT : rpfs_pkg::ST_DIV_INIT;
      rpfs_pkg::ST_SRCH_WT:   state_next = rpfs_pkg::ST_SRCH;
      rpfs_pkg::ST_DIV_INIT:
        state_next = status.div_bad ? rpfs_pkg::ST_COMP : rpfs_pkg::ST_DIV;
      rpfs_pkg::ST_DIV:
        if (status.div_last) state_next = rpfs_pkg::ST_COMP;
      rpfs_pkg::ST_COMP:
        state_next = status.interp ? rpfs_pkg::ST_INT_MUL : rpfs_pkg::ST_FRQ_MUL;
      rpfs_pkg::ST_INT_MUL:   state_next = rpfs_pkg::ST_INT_ADD;
      rpfs_pkg::ST_INT_ADD:   state_next = rpfs_pkg::ST_FRQ_MUL;
      rpfs_pkg::ST_FRQ_MUL:   state_next = rpfs_pkg::ST_ACC;
      rpfs_pkg::ST_ACC:
        state_next = status.last_comp ? rpfs_pkg::ST_NEXT : rpfs_pkg::ST_COMP;
      rpfs_pkg::ST_NEXT:      state_next = rpfs_pkg::ST_BALL;
      rpfs_pkg::ST_DONE:
        if (status.out_free) state_next = rpfs_pkg::ST_IDLE;
      default:                state_next = rpfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.op       = rpfs_pkg::OP_NONE;
    unique case (state)
      rpfs_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.op       = rpfs_pkg::OP_IDLE;
      end
      rpfs_pkg::ST_POS:       cmd.op = rpfs_pkg::OP_POS;
      rpfs_pkg::ST_BALL:      cmd.op = rpfs_pkg::OP_BALL;
      rpfs_pkg::ST_DIFF:      cmd.op = rpfs_pkg::OP_DIFF;
      rpfs_pkg::ST_SQR:       cmd.op = rpfs_pkg::OP_SQR;
      rpfs_pkg::ST_SQACC:     cmd.op = rpfs_pkg::OP_SQACC;
      rpfs_pkg::ST_ROOT_INIT: cmd.op = rpfs_pkg::OP_ROOT_INIT;
      rpfs_pkg::ST_ROOT:      cmd.op = rpfs_pkg::OP_ROOT;
      rpfs_pkg::ST_CHECK_N:   cmd.op = rpfs_pkg::OP_NONE;
      rpfs_pkg::ST_RD_FIRST:  cmd.op = rpfs_pkg::OP_RD_FIRST;
      rpfs_pkg::ST_WT_FIRST:  cmd.op = rpfs_pkg::OP_WT_FIRST;
      rpfs_pkg::ST_WT_LAST:   cmd.op = rpfs_pkg::OP_WT_LAST;
      rpfs_pkg::ST_SRCH:      cmd.op = rpfs_pkg::OP_SRCH_RD;
      rpfs_pkg::ST_SRCH_WT:   cmd.op = rpfs_pkg::OP_SRCH_WT;
      rpfs_pkg::ST_DIV_INIT:  cmd.op = rpfs_pkg::OP_DIV_INIT;
      rpfs_pkg::ST_DIV:       cmd.op = rpfs_pkg::OP_DIV;
      rpfs_pkg::ST_COMP:      cmd.op = rpfs_pkg::OP_COMP;
      rpfs_pkg::ST_INT_MUL:   cmd.op = rpfs_pkg::OP_INT_MUL;
      rpfs_pkg::ST_INT_ADD:   cmd.op = rpfs_pkg::OP_INT_ADD;
      rpfs_pkg::ST_FRQ_MUL:   cmd.op = rpfs_pkg::OP_FRQ_MUL;
      rpfs_pkg::ST_ACC:       cmd.op = rpfs_pkg::OP_ACC;
      rpfs_pkg::ST_NEXT:      cmd.op = rpfs_pkg::OP_NEXT;
      rpfs_pkg::ST_DONE:
        cmd.op = status.out_free ? rpfs_pkg::OP_EMIT : rpfs_pkg::OP_NONE;
      default:                cmd.op = rpfs_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== design/rpfs_datapath.sv =====
`timescale 1ns / 1ps
module rpfs_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rpfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpfs_pkg::CFG_DATA_W-1:0]    cfg_data,
  rpfs_item_if.sink                          items,
  rpfs_result_if.source                      results,
  input  rpfs_pkg::cmd_t                     cmd,
  output rpfs_pkg::status_t                  status
);

  function automatic logic signed [33:0] sx34(input logic [31:0] v);
    sx34 = {{2{v[31]}}, v};
  endfunction

  function automatic logic [32:0] clip36(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) begin
      clip36 = {1'b1, 32'h7FFFFFFF};
    end else if (v < 36'shF80000000) begin
      clip36 = {1'b1, 32'h80000000};
    end else begin
      clip36 = {1'b0, v[31:0]};
    end
  endfunction

  function automatic logic [32:0] clip52(input logic signed [51:0] v);
    if (v > 52'sh00000_7FFFFFFF) begin
      clip52 = {1'b1, 32'h7FFFFFFF};
    end else if (v < 52'shFFFFF_80000000) begin
      clip52 = {1'b1, 32'h80000000};
    end else begin
      clip52 = {1'b0, v[31:0]};
    end
  endfunction

  // configuration
  logic [rpfs_pkg::BC_W-1:0] ball_count;
  logic signed [31:0]        grid_origin;
  logic [30:0]               grid_spacing;

  // per-ball parameters
  logic [rpfs_pkg::ROW_W:0] rows_in_use [rpfs_pkg::MAX_BALLS];
  logic signed [31:0]       center      [rpfs_pkg::MAX_BALLS][3];
  logic signed [31:0]       freq        [rpfs_pkg::MAX_BALLS][3];

  // profile table
  rpfs_pkg::row_t              mem [rpfs_pkg::MEM_DEPTH];
  rpfs_pkg::row_t              rdata;
  logic [rpfs_pkg::ADDR_W-1:0] raddr;

  logic                         accept;
  logic [9:0]                   gidx [3];
  logic [1:0]                   ax;
  logic signed [42:0]           pos  [3];
  logic [40:0]                  pprod;
  logic [rpfs_pkg::CNT_W-1:0]   k;
  logic [rpfs_pkg::CNT_W-1:0]   nb;
  logic [rpfs_pkg::BALL_W-1:0]  kb;

  logic signed [43:0] dpos;
  logic               dclip;
  logic [30:0]        m_c;
  logic [30:0]        mag_d;
  logic [61:0]        sqp;
  logic [63:0]        sq;
  logic [63:0]        sqx;
  logic [63:0]        root;
  logic [63:0]        bitv;
  logic [63:0]        trial;
  logic [rpfs_pkg::IT_W-1:0] it;

  logic [rpfs_pkg::ROW_W:0]   n;
  logic [rpfs_pkg::ROW_W:0]   nm1;
  logic [rpfs_pkg::ROW_W:0]   mid_sum;
  logic [rpfs_pkg::ROW_W-1:0] lo;
  logic [rpfs_pkg::ROW_W-1:0] hi;
  logic [rpfs_pkg::ROW_W-1:0] mid;
  logic [rpfs_pkg::ROW_W-1:0] span;
  rpfs_pkg::row_t             lo_row;
  rpfs_pkg::row_t             hi_row;
  rpfs_pkg::mode_t            mode;

  logic signed [33:0]          r_s;
  logic signed [33:0]          num;
  logic signed [33:0]          den_c;
  logic [32:0]                 den;
  logic [34:0]                 rem;
  logic [34:0]                 rem2;
  logic                        dge;
  logic [rpfs_pkg::T_BITS-1:0] t;

  logic [1:0]         c;
  logic [31:0]        a_lo;
  logic [31:0]        a_hi;
  logic signed [32:0] dd;
  logic [32:0]        dmag;
  logic [62:0]        mprod;
  logic [63:0]        qsum;
  logic [33:0]        qext;
  logic signed [33:0] fnew;
  logic signed [31:0] f;
  logic signed [63:0] p;
  logic signed [63:0] vterm;
  logic signed [35:0] fsum [3];
  logic signed [51:0] vsum [3];
  logic               sat;

  logic [32:0] cf0, cf1, cf2, cv0, cv1, cv2;
  logic        out_valid;

  assign accept        = items.valid && items.ready;
  assign items.ready   = cmd.in_ready;
  assign results.valid = out_valid;

  assign kb  = k[rpfs_pkg::BALL_W-1:0];
  assign n   = rows_in_use[kb];
  assign nm1 = n - 1'b1;
  assign nb  = ({1'b0, ball_count} > rpfs_pkg::BALL_LIMIT) ?
               rpfs_pkg::BALL_LIMIT : {1'b0, ball_count};
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign span    = hi - lo;

  assign pprod = gidx[ax] * grid_spacing;

  always_comb begin
    dpos  = {pos[ax][42], pos[ax]} - {{12{center[kb][ax][31]}}, center[kb][ax]};
    dclip = 1'b0;
    m_c   = '0;
    if (dpos > 44'sh0007FFFFFFF || dpos < 44'shFFF80000001) begin
      dclip = 1'b1;
      m_c   = 31'h7FFFFFFF;
    end else if (dpos[43]) begin
      m_c = 31'(-dpos);
    end else begin
      m_c = dpos[30:0];
    end
  end

  assign trial = root + bitv;

  assign r_s   = {2'b00, root[31:0]};
  assign num   = r_s - sx34(lo_row.rad);
  assign den_c = sx34(hi_row.rad) - sx34(lo_row.rad);
  assign rem2  = {rem[33:0], 1'b0};
  assign dge   = rem2 >= {2'b00, den};

  always_comb begin
    a_lo = lo_row.amp[c];
    a_hi = hi_row.amp[c];
    dd   = {a_hi[31], a_hi} - {a_lo[31], a_lo};
    dmag = dd[32] ? 33'(-dd) : 33'(dd);
    // round the scaled step to nearest, then apply it toward the upper row
    qsum = {1'b0, mprod} + (64'd1 << (rpfs_pkg::T_BITS - 1));
    qext = {1'b0, qsum[rpfs_pkg::T_BITS +: 33]};
    fnew = dd[32] ? (sx34(a_lo) - $signed(qext)) : (sx34(a_lo) + $signed(qext));
  end

  assign vterm = (p + 64'sd32768) >>> rpfs_pkg::FRAC_BITS;

  always_comb begin
    unique case (cmd.op)
      rpfs_pkg::OP_RD_FIRST: raddr = {kb, rpfs_pkg::ROW_ZERO};
      rpfs_pkg::OP_WT_FIRST: raddr = {kb, nm1[rpfs_pkg::ROW_W-1:0]};
      default:               raddr = {kb, mid_sum[rpfs_pkg::ROW_W:1]};
    endcase
  end

  assign cf0 = clip36(fsum[0]);
  assign cf1 = clip36(fsum[1]);
  assign cf2 = clip36(fsum[2]);
  assign cv0 = clip52(vsum[0]);
  assign cv1 = clip52(vsum[1]);
  assign cv2 = clip52(vsum[2]);

  assign status.eval_accept = accept && (items.kind == rpfs_pkg::KIND_EVAL);
  assign status.last_axis   = (ax == 2'd2);
  assign status.ball_done   = (k == nb);
  assign status.root_last   = (it == rpfs_pkg::ROOT_LAST);
  assign status.n_small     = (n < rpfs_pkg::ROWS_MIN);
  assign status.r_le_first  = (r_s <= sx34(lo_row.rad));
  assign status.r_ge_last   = (r_s >= sx34(rdata.rad));
  assign status.span_gt1    = (span > rpfs_pkg::ROW_ONE);
  assign status.div_bad     = (den_c <= 34'sd0) || num[33];
  assign status.div_last    = (it == rpfs_pkg::DIV_LAST);
  assign status.interp      = (mode == rpfs_pkg::MODE_INTERP);
  assign status.last_comp   = (c == 2'd2);
  assign status.out_free    = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ball_count   <= rpfs_pkg::BC_W'(1);
      grid_origin  <= '0;
      grid_spacing <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        rpfs_pkg::CFG_BALL_COUNT:   ball_count   <= cfg_data[rpfs_pkg::BC_W-1:0];
        rpfs_pkg::CFG_GRID_ORIGIN:  grid_origin  <= cfg_data;
        rpfs_pkg::CFG_GRID_SPACING: grid_spacing <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < rpfs_pkg::MAX_BALLS; b++) begin
        rows_in_use[b] <= '0;
        for (int j = 0; j < 3; j++) begin
          center[b][j] <= '0;
          freq[b][j]   <= '0;
        end
      end
    end else if (accept) begin
      case (items.kind)
        rpfs_pkg::KIND_ROW:
          if (items.last_row) rows_in_use[items.ball] <= {1'b0, items.row} + 1'b1;
        rpfs_pkg::KIND_CENTER: begin
          center[items.ball][0] <= items.value_a;
          center[items.ball][1] <= items.value_b;
          center[items.ball][2] <= items.value_c;
        end
        rpfs_pkg::KIND_FREQ: begin
          freq[items.ball][0] <= items.value_a;
          freq[items.ball][1] <= items.value_b;
          freq[items.ball][2] <= items.value_c;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && items.kind == rpfs_pkg::KIND_ROW) begin
      mem[{items.ball, items.row}] <= '{rad: items.value_a,
                                        amp: {items.value_d, items.value_c, items.value_b}};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == rpfs_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rpfs_pkg::OP_IDLE:
        if (status.eval_accept) begin
          gidx[0] <= items.grid_x;
          gidx[1] <= items.grid_y;
          gidx[2] <= items.grid_z;
          ax      <= '0;
          k       <= '0;
          sat     <= 1'b0;
          for (int j = 0; j < 3; j++) begin
            fsum[j] <= '0;
            vsum[j] <= '0;
          end
        end
      rpfs_pkg::OP_POS: begin
        pos[ax] <= {{11{grid_origin[31]}}, grid_origin} + $signed({2'b00, pprod});
        ax      <= ax + 2'd1;
      end
      rpfs_pkg::OP_BALL: begin
        sq <= '0;
        ax <= '0;
        c  <= '0;
      end
      rpfs_pkg::OP_DIFF: begin
        mag_d <= m_c;
        if (dclip) sat <= 1'b1;
      end
      rpfs_pkg::OP_SQR:   sqp <= mag_d * mag_d;
      rpfs_pkg::OP_SQACC: begin
        sq <= sq + {2'b00, sqp};
        ax <= ax + 2'd1;
      end
      rpfs_pkg::OP_ROOT_INIT: begin
        sqx  <= sq;
        root <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        it   <= '0;
      end
      rpfs_pkg::OP_ROOT: begin
        if (sqx >= trial) begin
          sqx  <= sqx - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        it   <= it + 1'b1;
      end
      rpfs_pkg::OP_WT_FIRST: begin
        lo_row <= rdata;
        lo     <= rpfs_pkg::ROW_ZERO;
      end
      rpfs_pkg::OP_WT_LAST: begin
        hi_row <= rdata;
        hi     <= nm1[rpfs_pkg::ROW_W-1:0];
        if (status.r_le_first) begin
          mode <= rpfs_pkg::MODE_LO;
        end else if (status.r_ge_last) begin
          mode <= rpfs_pkg::MODE_ZERO;
        end else begin
          mode <= rpfs_pkg::MODE_INTERP;
        end
      end
      rpfs_pkg::OP_SRCH_RD: mid <= mid_sum[rpfs_pkg::ROW_W:1];
      rpfs_pkg::OP_SRCH_WT:
        if (sx34(rdata.rad) <= r_s) begin
          lo     <= mid;
          lo_row <= rdata;
        end else begin
          hi     <= mid;
          hi_row <= rdata;
        end
      rpfs_pkg::OP_DIV_INIT:
        if (status.div_bad) begin
          mode <= rpfs_pkg::MODE_LO;
        end else begin
          rem <= {1'b0, num};
          den <= den_c[32:0];
          t   <= '0;
          it  <= '0;
        end
      rpfs_pkg::OP_DIV: begin
        rem <= dge ? (rem2 - {2'b00, den}) : rem2;
        t   <= {t[rpfs_pkg::T_BITS-2:0], dge};
        it  <= it + 1'b1;
      end
      rpfs_pkg::OP_COMP:
        case (mode)
          rpfs_pkg::MODE_LO:   f <= a_lo;
          rpfs_pkg::MODE_ZERO: f <= '0;
          default: ;
        endcase
      rpfs_pkg::OP_INT_MUL: mprod <= dmag * t;
      rpfs_pkg::OP_INT_ADD: f <= fnew[31:0];
      rpfs_pkg::OP_FRQ_MUL: p <= freq[kb][c] * f;
      rpfs_pkg::OP_ACC: begin
        fsum[c] <= fsum[c] + {{4{f[31]}}, f};
        vsum[c] <= vsum[c] + vterm[51:0];
        c       <= c + 2'd1;
      end
      rpfs_pkg::OP_NEXT: k <= k + 1'b1;
      rpfs_pkg::OP_EMIT: begin
        results.field_0    <= cf0[31:0];
        results.field_1    <= cf1[31:0];
        results.field_2    <= cf2[31:0];
        results.velocity_0 <= cv0[31:0];
        results.velocity_1 <= cv1[31:0];
        results.velocity_2 <= cv2[31:0];
        results.saturated  <= sat | cf0[32] | cf1[32] | cf2[32] |
                              cv0[32] | cv1[32] | cv2[32];
      end
      default: ;
    endcase
  end

endmodule

// ===== design/radial_profile_field_seeder.sv =====
`timescale 1ns / 1ps
// Sums radial profile contributions of up to eight balls at grid voxels. Load items
// (profile rows, centers, frequencies) are taken while the block is idle. Per ball,
// an evaluate item runs the 32-step square root, one step a cycle; a ball with fewer
// than two rows stops there. Otherwise, where the radius lies between the first and
// last rows, a binary search with a registered profile table read at each step and
// the 30-step interpolation divider, one step a cycle, follow. Input is taken again
// while a finished result waits in the output register.
module radial_profile_field_seeder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rpfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpfs_pkg::CFG_DATA_W-1:0] cfg_data,
  rpfs_item_if.sink                       items,
  rpfs_result_if.source                   results
);

  rpfs_pkg::cmd_t    cmd;
  rpfs_pkg::status_t status;

  rpfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rpfs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .results   (results),
    .cmd       (cmd),
    .status    (status)
  );

`ifndef NO_ASSERTIONS
  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    status.eval_accept |=> cmd.op == rpfs_pkg::OP_POS)
    else $error("evaluate transfer did not start position stage");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.op == rpfs_pkg::OP_EMIT |=> results.valid)
    else $error("emitted result not presented");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == rpfs_pkg::OP_EMIT |-> status.out_free)
    else $error("result overwrote an untaken result");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.op != rpfs_pkg::OP_IDLE |-> !items.ready)
    else $error("input taken during evaluation");
`endif

endmodule
